>>> rtl/core/segmented_length_code_decoder_defines.svh
// Assertion macros for the segmented length code decoder.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef SEGMENTED_LENGTH_CODE_DECODER_DEFINES_SVH
`define SEGMENTED_LENGTH_CODE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge out of reset
`define SLCD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("slcd assertion failed");
// condition must never be true out of reset
`define SLCD_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("slcd forbidden condition seen");
`else
`define SLCD_ASSERT(label, prop)
`define SLCD_ASSERT_NEVER(label, cond)
`endif

`endif

>>> rtl/core/slcd_pkg.sv
// Types and constants of the segmented length code decoder.
// No dependencies.
`default_nettype none

package slcd_pkg;

  localparam int HEADER_BITS = 3;
  localparam int TABLE_DEPTH = 247;
  localparam int IDX_W       = 8;
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 3;
  localparam int ACC_W       = 7;
  localparam int CMD_DEPTH   = 2;

  typedef struct packed {
    logic              action;
    logic [IDX_W-1:0]  entry_index;
    logic [CHAR_W-1:0] entry_char;
    logic              code_bit;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              end_of_message;
  } out_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_END
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [IDX_W-1:0]  addr;
    logic [CHAR_W-1:0] data;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/segmented_length_code_decoder.sv
// Segmented length code decoder, top level.
// Depends on slcd_pkg, slcd_front, slcd_cmd_fifo, slcd_back and the defines header.
//
// Usage:
//   Input side is a queue write port: a transfer happens on a clock edge with
//   push high and full low. action=0 loads entry_char at entry_index into the
//   character table (index above 246 is dropped); action=1 feeds one code bit,
//   MSB first. A 3-bit header sets the code length; header zero yields an end
//   marker. Codes follow until the all-ones code closes the segment.
//   Result side is a queue read port: while empty is low the oldest result is
//   on out_data_o; it transfers on an edge with pop high.
//   Throughput: one item per cycle while full stays low, set by the combinational
//   bit shift/compare in the front end and the single table port in the back end.
//   A result's command enters the queue at the transfer edge; the registered
//   table read then fills the result register once no older command waits
//   ahead of it and the result register is free.
//   Stall: when pop stays low the result register holds, the two-entry command
//   queue fills and full rises; loads still drain behind a held result only
//   up to the queue head. Reset clears the decoder state and both queues;
//   the table content is undefined until loaded and is never cleared.
`default_nettype none
`include "segmented_length_code_decoder_defines.svh"

module segmented_length_code_decoder (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire slcd_pkg::in_t in_data_i,
  output logic               empty,
  input  wire logic          pop,
  output slcd_pkg::out_t     out_data_o
);

  logic           accept;
  logic           cmd_push;
  slcd_pkg::cmd_t cmd_in;
  logic           cmd_valid;
  slcd_pkg::cmd_t cmd_head;
  logic           cmd_take;

  // an item transfers whenever the command queue has room
  assign accept = push && !full;

  slcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_in)
  );

  slcd_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_take),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_head)
  );

  slcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_take_o  (cmd_take),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_data_o  (out_data_o)
  );

  // end marker always carries a zero character
  `SLCD_ASSERT(a_eom_zero_char, (!empty && out_data_o.end_of_message) |-> (out_data_o.char_out == '0))
  // a result command only enters the result register when it is free
  `SLCD_ASSERT_NEVER(a_no_overwrite, cmd_take && (cmd_head.op != slcd_pkg::CMD_WRITE) && !empty && !pop)
  // table writes stay inside the table
  `SLCD_ASSERT(a_write_in_range, (cmd_push && cmd_in.op == slcd_pkg::CMD_WRITE) |-> (cmd_in.addr < 8'd247))

endmodule

`default_nettype wire

>>> rtl/core/slcd_front.sv
// Front end: takes input items, tracks header/code phase, issues table commands.
// Depends on slcd_pkg.
`default_nettype none

module slcd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire slcd_pkg::in_t item_i,
  output logic               cmd_valid_o,
  output slcd_pkg::cmd_t     cmd_o
);

  logic                         phase_q, phase_d;
  logic [slcd_pkg::LEN_W-1:0]   len_q, len_d;
  logic [slcd_pkg::LEN_W-1:0]   cnt_q, cnt_d;
  logic [slcd_pkg::ACC_W-1:0]   acc_q, acc_d;

  logic [slcd_pkg::ACC_W-1:0]   acc_next;
  logic [slcd_pkg::LEN_W-1:0]   cnt_next;
  logic [slcd_pkg::LEN_W-1:0]   target;
  logic [slcd_pkg::ACC_W-1:0]   ones;
  logic [slcd_pkg::IDX_W-1:0]   pos;

  always_comb begin
    acc_next = {acc_q[slcd_pkg::ACC_W-2:0], item_i.code_bit};
    cnt_next = cnt_q + 1'b1;
    target   = phase_q ? len_q : slcd_pkg::LEN_W'(slcd_pkg::HEADER_BITS);
    ones     = slcd_pkg::ACC_W'((8'd1 << len_q) - 8'd1);
    pos      = {1'b0, ones} - {5'd0, len_q} + {1'b0, acc_next};

    phase_d     = phase_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    cmd_valid_o = 1'b0;
    cmd_o.op    = slcd_pkg::CMD_WRITE;
    cmd_o.addr  = item_i.entry_index;
    cmd_o.data  = item_i.entry_char;

    if (!item_i.action) begin
      // load: out-of-range index is dropped
      cmd_valid_o = accept_i && (item_i.entry_index < slcd_pkg::IDX_W'(slcd_pkg::TABLE_DEPTH));
    end else if (accept_i) begin
      if (cnt_next != target) begin
        acc_d = acc_next;
        cnt_d = cnt_next;
      end else begin
        acc_d = '0;
        cnt_d = '0;
        if (!phase_q) begin
          if (acc_next == '0) begin
            cmd_valid_o = 1'b1;
            cmd_o.op    = slcd_pkg::CMD_END;
          end else begin
            len_d   = acc_next[slcd_pkg::LEN_W-1:0];
            phase_d = 1'b1;
          end
        end else if (acc_next == ones) begin
          phase_d = 1'b0;  // all-ones code closes the segment
        end else begin
          cmd_valid_o = 1'b1;
          cmd_o.op    = slcd_pkg::CMD_READ;
          cmd_o.addr  = pos;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      len_q   <= '0;
      cnt_q   <= '0;
      acc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/slcd_cmd_fifo.sv
// Two-entry command queue between front and back end.
// Depends on slcd_pkg.
`default_nettype none

module slcd_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire slcd_pkg::cmd_t cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output slcd_pkg::cmd_t      cmd_o
);

  localparam int PTR_W = $clog2(slcd_pkg::CMD_DEPTH);
  localparam int CNT_W = $clog2(slcd_pkg::CMD_DEPTH + 1);

  slcd_pkg::cmd_t     slots_q [slcd_pkg::CMD_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(slcd_pkg::CMD_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(slcd_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(slcd_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/slcd_back.sv
// Back end: character table memory and the result register.
// Depends on slcd_pkg.
`default_nettype none

module slcd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire slcd_pkg::cmd_t cmd_i,
  output logic                cmd_take_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output slcd_pkg::out_t      out_data_o
);

  logic [slcd_pkg::CHAR_W-1:0] table_mem [slcd_pkg::TABLE_DEPTH];
  logic [slcd_pkg::CHAR_W-1:0] rd_q;
  logic                        out_valid_q, out_valid_d;
  logic                        eom_q, eom_d;
  logic                        out_room;
  logic                        wr_en, rd_en;

  assign out_room = !out_valid_q || pop_i;

  always_comb begin
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    cmd_take_o  = 1'b0;
    out_valid_d = out_valid_q && !pop_i;
    eom_d       = eom_q;
    if (cmd_valid_i) begin
      case (cmd_i.op)
        slcd_pkg::CMD_WRITE: begin
          wr_en      = 1'b1;
          cmd_take_o = 1'b1;
        end
        slcd_pkg::CMD_READ: begin
          if (out_room) begin
            rd_en       = 1'b1;
            cmd_take_o  = 1'b1;
            out_valid_d = 1'b1;
            eom_d       = 1'b0;
          end
        end
        slcd_pkg::CMD_END: begin
          if (out_room) begin
            cmd_take_o  = 1'b1;
            out_valid_d = 1'b1;
            eom_d       = 1'b1;
          end
        end
        default: begin
          cmd_take_o = 1'b1;  // drop unknown codes
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[cmd_i.addr] <= cmd_i.data;
    end
    if (rd_en) begin
      rd_q <= table_mem[cmd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      eom_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      eom_q       <= eom_d;
    end
  end

  assign empty_o                   = !out_valid_q;
  assign out_data_o.char_out       = eom_q ? '0 : rd_q;
  assign out_data_o.end_of_message = eom_q;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for segmented_length_code_decoder: table loads and code bits in,
// decoded characters and end markers out, checked against an in-bench decoder model.
// Depends on slcd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb_top;
  import slcd_pkg::*;

  localparam int    HALF_PERIOD = 10;
  localparam int    ITEMS       = 1700;        // live items to send, directed rows included
  localparam int    CYCLE_LIMIT = 1_000_000;   // watchdog
  localparam int    DRAIN       = 16;          // settle time after the last result
  localparam int    MAX_REPORTS = 10;

  // action codes of an input item
  localparam logic  ACT_LOAD = 1'b0;
  localparam logic  ACT_BIT  = 1'b1;
  // directed rows with a result typed in by hand
  localparam logic  PINNED   = 1'b1;
  localparam logic  FREE     = 1'b0;

  typedef struct {
    in_t  item;
    logic pinned;
    out_t want;
  } stim_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic pop    = 1'b0;
  in_t  in_data_i = '0;
  logic full;
  logic empty;
  out_t out_data_o;

  segmented_length_code_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Decoder model: own copy of the table and of the segment state. Advanced
  // once per input transfer, in transfer order.
  // ---------------------------------------------------------------------------
  logic [CHAR_W-1:0] dec_chars [TABLE_DEPTH];
  logic              dec_in_code = 1'b0;   // 0: collecting a header
  logic [LEN_W-1:0]  dec_len     = '0;
  logic [2:0]        dec_cnt     = '0;
  logic [ACC_W-1:0]  dec_acc     = '0;

  out_t pending_chars [$];   // expected results, oldest first
  int   n_errors = 0;
  int   cycle_n  = 0;

  function automatic bit decode_item(input in_t it, output out_t res);
    logic [LEN_W-1:0] target;
    logic [ACC_W-1:0] value;
    int               ones;
    int               pos;
    res = '0;
    if (it.action == ACT_LOAD) begin
      if (it.entry_index < TABLE_DEPTH) dec_chars[it.entry_index] = it.entry_char;
      return 1'b0;
    end
    dec_acc = {dec_acc[ACC_W-2:0], it.code_bit};
    dec_cnt = dec_cnt + 3'd1;
    target  = dec_in_code ? dec_len : LEN_W'(HEADER_BITS);
    if (dec_cnt != target) return 1'b0;
    value   = dec_acc;
    dec_cnt = '0;
    dec_acc = '0;
    if (!dec_in_code) begin
      // zero header closes the message, table survives
      if (value == '0) begin
        res.end_of_message = 1'b1;
        return 1'b1;
      end
      dec_len     = value[LEN_W-1:0];
      dec_in_code = 1'b1;
      return 1'b0;
    end
    ones = (1 << dec_len) - 1;
    if (int'(value) == ones) begin
      // all-ones code ends the segment silently
      dec_in_code = 1'b0;
      return 1'b0;
    end
    pos = ones - int'(dec_len) + int'(value);
    res.char_out = (pos < TABLE_DEPTH) ? dec_chars[pos] : '0;
    return 1'b1;
  endfunction

  task automatic flag(input string what);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("mismatch: %s", what);
  endtask

  // Idle gaps: mostly none or short, a few long, plus calm stretches with
  // back-to-back transfers so gaps land on every phase of a segment.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation. Runs ahead of driving; the generator tracks which
  // table slots are loaded so that no code ever reads an unloaded slot.
  // Until the table is full only complete messages are sent (header phase at
  // each message start); after that noise and cut-off messages mix in.
  // ---------------------------------------------------------------------------
  stim_t stim_q [$];
  stim_t directed_rows [24];
  bit    gen_loaded [TABLE_DEPTH];
  int    gen_loaded_n = 0;
  int    live_items   = 0;

  function automatic stim_t mk(input logic act, input logic [IDX_W-1:0] idx,
                               input logic [CHAR_W-1:0] chr, input logic b,
                               input logic pin, input logic [CHAR_W-1:0] wc,
                               input logic weom);
    stim_t s;
    s.item.action      = act;
    s.item.entry_index = idx;
    s.item.entry_char  = chr;
    s.item.code_bit    = b;
    s.pinned           = pin;
    s.want.char_out    = wc;
    s.want.end_of_message = weom;
    return s;
  endfunction

  task automatic add_stim(input stim_t s);
    stim_q.insert(stim_q.size(), s);
    if (s.item.action == ACT_LOAD && s.item.entry_index >= TABLE_DEPTH) return;
    live_items++;
    if (s.item.action == ACT_LOAD && !gen_loaded[s.item.entry_index]) begin
      gen_loaded[s.item.entry_index] = 1'b1;
      gen_loaded_n++;
    end
  endtask

  task automatic add_load();
    int r;
    int idx;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      idx = $urandom_range(TABLE_DEPTH, 255);   // dropped by the block
    end else if (gen_loaded_n < TABLE_DEPTH && r < 85) begin
      idx = 0;                                  // lowest free slot first
      while (gen_loaded[idx]) idx++;
    end else begin
      idx = $urandom_range(0, TABLE_DEPTH - 1);
    end
    add_stim(mk(ACT_LOAD, idx[IDX_W-1:0], CHAR_W'($urandom), 1'($urandom),
                FREE, '0, 1'b0));
  endtask

  task automatic add_bit(input logic b);
    int load_pct;
    load_pct = (gen_loaded_n < TABLE_DEPTH) ? 45 : 8;
    if ($urandom_range(0, 99) < load_pct) add_load();
    add_stim(mk(ACT_BIT, IDX_W'($urandom), CHAR_W'($urandom), b, FREE, '0, 1'b0));
  endtask

  function automatic bit has_loaded(input int len);
    int base;
    base = (1 << len) - len - 1;
    for (int v = 0; v < (1 << len) - 1; v++)
      if (gen_loaded[base + v]) return 1'b1;
    return 1'b0;
  endfunction

  task automatic add_message();
    bit msg [$];
    int len;
    int base;
    int v;
    int cut;
    int mode;
    bit tbl_full;
    tbl_full = (gen_loaded_n == TABLE_DEPTH);
    mode     = $urandom_range(0, 99);
    if (tbl_full && mode < 10) begin
      // raw noise, any state is safe once every slot is loaded
      repeat ($urandom_range(1, 12)) add_bit(1'($urandom));
      return;
    end
    if (mode < 22) begin
      repeat (HEADER_BITS) msg.insert(msg.size(), 1'b0);
    end else begin
      len = $urandom_range(1, 7);
      for (int t = 0; t < 8 && !has_loaded(len); t++) len = $urandom_range(1, 7);
      base = (1 << len) - len - 1;
      for (int k = HEADER_BITS - 1; k >= 0; k--) msg.insert(msg.size(), len[k]);
      repeat ($urandom_range(0, 8)) begin
        v = $urandom_range(0, (1 << len) - 2);
        if (gen_loaded[base + v])
          for (int k = len - 1; k >= 0; k--) msg.insert(msg.size(), v[k]);
      end
      repeat (len) msg.insert(msg.size(), 1'b1);
    end
    cut = msg.size();
    if (tbl_full && mode >= 88) cut = $urandom_range(1, msg.size() - 1);
    for (int k = 0; k < cut; k++) add_bit(msg[k]);
  endtask

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: walk the stimulus, one push transfer per item. The model is
  // stepped at the edge where push is high and full is low.
  // ---------------------------------------------------------------------------
  initial begin
    out_t res;
    int   gap;
    int   tx_calm;
    tx_calm = 0;
    foreach (dec_chars[i]) dec_chars[i] = '0;

    directed_rows = '{
      // table extremes; slot 255 is past the end and must be dropped
      mk(ACT_LOAD, 8'd0,   8'h00, 1'b0, FREE,   8'h00, 1'b0),
      mk(ACT_LOAD, 8'd246, 8'hFF, 1'b1, FREE,   8'h00, 1'b0),
      mk(ACT_LOAD, 8'd255, 8'hAA, 1'b1, FREE,   8'h00, 1'b0),
      // zero header: end marker with zero char; load fields ignored on bits
      mk(ACT_BIT,  8'hFF,  8'hFF, 1'b0, FREE,   8'h00, 1'b0),
      mk(ACT_BIT,  8'hFF,  8'hFF, 1'b0, FREE,   8'h00, 1'b0),
      mk(ACT_BIT,  8'hFF,  8'hFF, 1'b0, PINNED, 8'h00, 1'b1),
      // header 7: longest codes
      mk(ACT_BIT,  8'h00,  8'h00, 1'b1, FREE,   8'h00, 1'b0),
      mk(ACT_BIT,  8'h00,  8'h00, 1'b1, FREE,   8'h00, 1'b0),
      mk(ACT_BIT,  8'h00,  8'h00, 1'b1, FREE,   8'h00, 1'b0),
      // code 126 reads the last slot; a load lands in the middle of the code
      mk(ACT_BIT,  8'h00,  8'h00, 1'b1, FREE,   8'h00, 1'b0),
      mk(ACT_BIT,  8'h00,  8'h00, 1'b1, FREE,   8'h00, 1'b0),
      mk(ACT_BIT,  8'h00,  8'h00, 1'b1, FREE,   8'h00, 1'b0),
      mk(ACT_LOAD, 8'd1,   8'h41, 1'b0, FREE,   8'h00, 1'b0),
      mk(ACT_BIT,  8'h00,  8'h00, 1'b1, FREE,   8'h00, 1'b0),
      mk(ACT_BIT,  8'h00,  8'h00, 1'b1, FREE,   8'h00, 1'b0),
      mk(ACT_BIT,  8'h00,  8'h00, 1'b1, FREE,   8'h00, 1'b0),
      mk(ACT_BIT,  8'h00,  8'h00, 1'b0, PINNED, 8'hFF, 1'b0),
      // all-ones code closes the segment, nothing comes out
      mk(ACT_BIT,  8'h00,  8'h00, 1'b1, FREE,   8'h00, 1'b0),
      mk(ACT_BIT,  8'h00,  8'h00, 1'b1, FREE,   8'h00, 1'b0),
      mk(ACT_BIT,  8'h00,  8'h00, 1'b1, FREE,   8'h00, 1'b0),
      mk(ACT_BIT,  8'h00,  8'h00, 1'b1, FREE,   8'h00, 1'b0),
      mk(ACT_BIT,  8'h00,  8'h00, 1'b1, FREE,   8'h00, 1'b0),
      mk(ACT_BIT,  8'h00,  8'h00, 1'b1, FREE,   8'h00, 1'b0),
      mk(ACT_BIT,  8'h00,  8'h00, 1'b1, FREE,   8'h00, 1'b0)
    };
    foreach (directed_rows[i]) add_stim(directed_rows[i]);
    while (live_items < ITEMS) add_message();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_q[i]) begin
      gap = pick_gap(tx_calm);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      push      <= 1'b1;
      in_data_i <= stim_q[i].item;
      @(posedge clk_i);
      while (full) @(posedge clk_i);
      // transfer at this edge
      if (decode_item(stim_q[i].item, res))
        pending_chars.insert(pending_chars.size(),
                             stim_q[i].pinned ? stim_q[i].want : res);
    end
    push <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: pop with random stalls, compare each transfer field by field
  // against the oldest expectation.
  // ---------------------------------------------------------------------------
  initial begin
    out_t want;
    out_t got;
    int   gap;
    int   rx_calm;
    rx_calm = 0;
    wait (rst_ni == 1'b1);
    forever begin
      gap = pick_gap(rx_calm);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      got = out_data_o;
      if (pending_chars.size() == 0) begin
        flag($sformatf("unexpected result char_out=%02h end_of_message=%0b",
                       got.char_out, got.end_of_message));
      end else begin
        want = pending_chars.pop_front();
        if (got.char_out !== want.char_out)
          flag($sformatf("char_out exp %02h got %02h", want.char_out, got.char_out));
        if (got.end_of_message !== want.end_of_message)
          flag($sformatf("end_of_message exp %0b got %0b",
                         want.end_of_message, got.end_of_message));
      end
    end
  end

endmodule
